// ===== rtl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants of the step pulse generator
// Field widths, request codes, decoded command codes, queue entry layout and
// configuration register map.
// ----------------------------------------------------------------------------
package stp_pkg;

  // payload widths
  localparam int REQ_W        = 3;
  localparam int VEL_W        = 24;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 32;
  localparam int PERIOD_OUT_W = 24;

  // configuration register widths and reset values
  localparam int SPR_W  = 16;
  localparam int MINP_W = 16;
  localparam int PW_W   = 8;
  localparam logic [SPR_W-1:0]  SPR_RST  = 16'd200;
  localparam logic [MINP_W-1:0] MINP_RST = 16'd100;
  localparam logic [PW_W-1:0]   PW_RST   = 8'd2;

  // apb register map
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_SPR  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MINP = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PW   = 2'd2;

  // period arithmetic: 2 * 1e6 * 65536 over 2 * steps_per_rev * |velocity|
  localparam int PERIOD_BITS_DEF = 24;
  localparam int DEN_W           = SPR_W + VEL_W;
  localparam int DVS_W           = DEN_W + 1;
  localparam logic [DEN_W-1:0] TWO_TICKS_Q16 = 40'd131072000000;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_VEL     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_MOVE_AB = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MOVE_RL = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ENABLE  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DISABLE = 3'd5;

  // decoded commands
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_RUN,
    CMD_HALT,
    CMD_MOVE_ABS,
    CMD_MOVE_REL,
    CMD_ENABLE,
    CMD_DISABLE
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic             fwd;
    logic [VEL_W-1:0] mag;
    logic [VAL_W-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic [SPR_W-1:0]  spr;
    logic [MINP_W-1:0] min_period;
    logic [PW_W-1:0]   pulse_width;
  } cfg_t;

endpackage

// ===== rtl/stp_in_if.sv =====
// ----------------------------------------------------------------------------
// stp_in_if: request channel of the step pulse generator
// Valid/ready channel carrying one motion request or tick.
// ----------------------------------------------------------------------------
interface stp_in_if;
  logic                               valid;
  logic                               ready;
  logic        [stp_pkg::REQ_W-1:0]   req_type;
  logic signed [stp_pkg::VEL_W-1:0]   velocity;
  logic signed [stp_pkg::VAL_W-1:0]   step_value;

  modport source (output valid, req_type, velocity, step_value, input ready);
  modport sink   (input valid, req_type, velocity, step_value, output ready);
endinterface

// ===== rtl/stp_out_if.sv =====
// ----------------------------------------------------------------------------
// stp_out_if: status channel of the step pulse generator
// Valid/ready channel carrying the output state after each request.
// ----------------------------------------------------------------------------
interface stp_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    step_level;
  logic                                    dir_level;
  logic                                    enable_n;
  logic signed [stp_pkg::POS_W-1:0]        position;
  logic                                    is_moving;
  logic        [stp_pkg::PERIOD_OUT_W-1:0] period_out;

  modport source (output valid, step_level, dir_level, enable_n, position, is_moving,
                  period_out, input ready);
  modport sink   (input valid, step_level, dir_level, enable_n, position, is_moving,
                  period_out, output ready);
endinterface

// ===== rtl/stp_front.sv =====
// ----------------------------------------------------------------------------
// stp_front: request decode and command queue
// Accepts requests, classifies them into commands and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module stp_front (
  input  logic              clk,
  input  logic              rst_n,
  stp_in_if.sink            in_if,
  output logic              head_valid,
  output stp_pkg::q_entry_t head,
  input  logic              pop
);

  localparam int PTR_W = (stp_pkg::QUEUE_DEPTH > 1) ? $clog2(stp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(stp_pkg::QUEUE_DEPTH + 1);

  stp_pkg::q_entry_t             mem_r [stp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]              wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]              rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          push;
  logic [stp_pkg::VEL_W-1:0]     vel_u;
  logic                          neg;
  logic                          vzero;
  stp_pkg::q_entry_t             entry;

  // classify the request
  assign vel_u = in_if.velocity;
  assign neg   = vel_u[stp_pkg::VEL_W-1];
  assign vzero = (vel_u == '0);

  always_comb begin
    entry.fwd   = ~neg;
    entry.mag   = neg ? (~vel_u + stp_pkg::VEL_W'(1)) : vel_u;
    entry.value = in_if.step_value;
    case (in_if.req_type)
      stp_pkg::REQ_TICK:    entry.cmd = stp_pkg::CMD_TICK;
      stp_pkg::REQ_VEL:     entry.cmd = vzero ? stp_pkg::CMD_HALT : stp_pkg::CMD_RUN;
      stp_pkg::REQ_MOVE_AB: entry.cmd = (neg || vzero) ? stp_pkg::CMD_HALT
                                                       : stp_pkg::CMD_MOVE_ABS;
      stp_pkg::REQ_MOVE_RL: entry.cmd = (neg || vzero) ? stp_pkg::CMD_HALT
                                                       : stp_pkg::CMD_MOVE_REL;
      stp_pkg::REQ_ENABLE:  entry.cmd = stp_pkg::CMD_ENABLE;
      stp_pkg::REQ_DISABLE: entry.cmd = stp_pkg::CMD_DISABLE;
      default:              entry.cmd = stp_pkg::CMD_NOP;
    endcase
  end

  // queue pointers and fill count
  assign in_if.ready = (cnt_r != CNT_W'(stp_pkg::QUEUE_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign head_valid  = (cnt_r != '0);
  assign head        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(stp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(stp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ===== rtl/stp_div.sv =====
// ----------------------------------------------------------------------------
// stp_div: step period calculator
// Multiplies steps per revolution by speed, then runs a restoring divider one
// quotient bit per cycle, with saturation and the minimum period clamp.
// ----------------------------------------------------------------------------
module stp_div #(
  parameter int PERIOD_BITS = stp_pkg::PERIOD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [stp_pkg::SPR_W-1:0]   spr,
  input  logic [stp_pkg::VEL_W-1:0]   mag,
  input  logic [stp_pkg::MINP_W-1:0]  min_period,
  output logic                        done,
  output logic [PERIOD_BITS-1:0]      period
);

  localparam int IT_W = $clog2(PERIOD_BITS);
  localparam int HI_W = stp_pkg::DEN_W - PERIOD_BITS;

  typedef enum logic [3:0] {
    DV_IDLE  = 4'b0001,
    DV_SETUP = 4'b0010,
    DV_ITER  = 4'b0100,
    DV_FIN   = 4'b1000
  } dv_state_t;

  dv_state_t                     state_r, state_nxt;
  logic                          done_r, done_nxt;
  logic [stp_pkg::DEN_W-1:0]     den_r;
  logic [stp_pkg::DVS_W-1:0]     rem_r;
  logic [PERIOD_BITS-1:0]        nsh_r;
  logic [PERIOD_BITS-1:0]        quot_r;
  logic [IT_W-1:0]               it_r;
  logic [PERIOD_BITS-1:0]        period_r;

  logic [stp_pkg::DEN_W-1:0]     num;
  logic [stp_pkg::DVS_W-1:0]     dvs;
  logic [HI_W-1:0]               num_hi;
  logic                          ovf;
  logic [stp_pkg::DVS_W:0]       trial;
  logic [stp_pkg::DVS_W:0]       diff;
  logic                          qbit;
  logic [stp_pkg::MINP_W-1:0]    lo;
  logic [PERIOD_BITS-1:0]        lo_ext;

  // numerator carries the half divisor for rounding
  assign num    = stp_pkg::TWO_TICKS_Q16 + den_r;
  assign dvs    = {den_r, 1'b0};
  assign num_hi = num[stp_pkg::DEN_W-1:PERIOD_BITS];
  assign ovf    = (stp_pkg::DVS_W'(num_hi) >= dvs);

  // one restoring step
  assign trial = {rem_r, nsh_r[PERIOD_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = (trial >= {1'b0, dvs});

  assign lo     = (min_period == '0) ? stp_pkg::MINP_W'(1) : min_period;
  assign lo_ext = PERIOD_BITS'(lo);

  assign done   = done_r;
  assign period = period_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    case (state_r)
      DV_IDLE:  if (start) state_nxt = DV_SETUP;
      DV_SETUP: state_nxt = (den_r == '0 || ovf) ? DV_FIN : DV_ITER;
      DV_ITER:  if (it_r == '0) state_nxt = DV_FIN;
      DV_FIN: begin
        done_nxt  = 1'b1;
        state_nxt = DV_IDLE;
      end
      default:  state_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      DV_IDLE: begin
        den_r <= stp_pkg::DEN_W'(spr) * stp_pkg::DEN_W'(mag);
      end
      DV_SETUP: begin
        quot_r <= '1;
        rem_r  <= stp_pkg::DVS_W'(num_hi);
        nsh_r  <= num[PERIOD_BITS-1:0];
        it_r   <= IT_W'(PERIOD_BITS - 1);
      end
      DV_ITER: begin
        rem_r  <= qbit ? diff[stp_pkg::DVS_W-1:0] : trial[stp_pkg::DVS_W-1:0];
        quot_r <= {quot_r[PERIOD_BITS-2:0], qbit};
        nsh_r  <= {nsh_r[PERIOD_BITS-2:0], 1'b0};
        it_r   <= it_r - IT_W'(1);
      end
      DV_FIN: begin
        period_r <= (quot_r < lo_ext) ? lo_ext : quot_r;
      end
      default: begin
        period_r <= period_r;
      end
    endcase
  end

endmodule

// ===== rtl/stp_back.sv =====
// ----------------------------------------------------------------------------
// stp_back: motion state and command execution
// Takes commands from the queue, updates position, direction and step timing,
// runs the period calculator for speed commands and registers the status.
// ----------------------------------------------------------------------------
module stp_back #(
  parameter int PERIOD_BITS = stp_pkg::PERIOD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  stp_pkg::q_entry_t head,
  output logic              pop,
  input  stp_pkg::cfg_t     cfg,
  stp_out_if.source         out_if
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_PUT  = 3'b100
  } bk_state_t;

  bk_state_t                    state_r, state_nxt;
  logic [stp_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [stp_pkg::POS_W-1:0]    tgt_r, tgt_nxt;
  logic                         mode_r, mode_nxt;
  logic                         dir_r, dir_nxt;
  logic                         moving_r, moving_nxt;
  logic                         en_n_r, en_n_nxt;
  logic [PERIOD_BITS-1:0]       period_r, period_nxt;
  logic [PERIOD_BITS-1:0]       pcnt_r, pcnt_nxt;
  logic [stp_pkg::PW_W-1:0]     pulse_r, pulse_nxt;
  logic                         step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic                         div_start;
  logic                         div_done;
  logic [PERIOD_BITS-1:0]       div_period;
  logic [stp_pkg::PW_W-1:0]     pulse_dec;
  logic [PERIOD_BITS-1:0]       cnt_inc;
  logic [stp_pkg::POS_W-1:0]    move_tgt;
  logic                         step_dir;
  logic                         do_stop;
  logic                         do_halt;
  logic                         out_load;

  stp_div #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .spr        (cfg.spr),
    .mag        (head.mag),
    .min_period (cfg.min_period),
    .done       (div_done),
    .period     (div_period)
  );

  assign pulse_dec = pulse_r - stp_pkg::PW_W'(1);
  assign cnt_inc   = pcnt_r + PERIOD_BITS'(1);
  assign move_tgt  = (head.cmd == stp_pkg::CMD_MOVE_ABS) ? head.value : pos_r + head.value;
  assign step_dir  = mode_r ? ($signed(tgt_r) > $signed(pos_r)) : dir_r;
  assign out_load  = (state_r == BK_PUT) && (!out_valid_r || out_if.ready);

  // command execution
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    tgt_nxt    = tgt_r;
    mode_nxt   = mode_r;
    dir_nxt    = dir_r;
    moving_nxt = moving_r;
    en_n_nxt   = en_n_r;
    period_nxt = period_r;
    pcnt_nxt   = pcnt_r;
    pulse_nxt  = pulse_r;
    step_nxt   = step_r;
    pop        = 1'b0;
    div_start  = 1'b0;
    do_stop    = 1'b0;
    do_halt    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          pop       = 1'b1;
          state_nxt = BK_PUT;
          case (head.cmd)
            stp_pkg::CMD_TICK: begin
              // pulse timer first, then the period counter
              if (pulse_r != '0) begin
                pulse_nxt = pulse_dec;
                if (pulse_dec == '0) step_nxt = 1'b0;
              end
              if (moving_r) begin
                if (cnt_inc < period_r) begin
                  pcnt_nxt = cnt_inc;
                end else begin
                  pcnt_nxt = '0;
                  if (mode_r && pos_r == tgt_r) begin
                    do_stop = 1'b1;
                  end else begin
                    dir_nxt   = step_dir;
                    step_nxt  = 1'b1;
                    pulse_nxt = (cfg.pulse_width == '0) ? stp_pkg::PW_W'(1)
                                                        : cfg.pulse_width;
                    pos_nxt   = step_dir ? pos_r + stp_pkg::POS_W'(1)
                                         : pos_r - stp_pkg::POS_W'(1);
                  end
                end
              end
            end
            stp_pkg::CMD_RUN: begin
              dir_nxt   = head.fwd;
              mode_nxt  = 1'b0;
              div_start = 1'b1;
              state_nxt = BK_DIV;
            end
            stp_pkg::CMD_HALT: begin
              do_halt = 1'b1;
            end
            stp_pkg::CMD_MOVE_ABS, stp_pkg::CMD_MOVE_REL: begin
              if (move_tgt == pos_r) begin
                do_halt = 1'b1;
              end else begin
                tgt_nxt   = move_tgt;
                mode_nxt  = 1'b1;
                dir_nxt   = $signed(move_tgt) > $signed(pos_r);
                div_start = 1'b1;
                state_nxt = BK_DIV;
              end
            end
            stp_pkg::CMD_ENABLE: begin
              en_n_nxt = 1'b0;
            end
            stp_pkg::CMD_DISABLE: begin
              do_stop  = 1'b1;
              en_n_nxt = 1'b1;
            end
            default: begin
              state_nxt = BK_PUT;
            end
          endcase
        end
      end
      BK_DIV: begin
        // new period restarts the counter only when it differs
        if (div_done) begin
          moving_nxt = 1'b1;
          if (div_period != period_r) begin
            period_nxt = div_period;
            pcnt_nxt   = '0;
          end
          state_nxt = BK_PUT;
        end
      end
      BK_PUT: begin
        if (out_load) state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    // stop and halt share the clearing of the motion state
    if (do_stop || do_halt) begin
      moving_nxt = 1'b0;
      period_nxt = '0;
      pcnt_nxt   = '0;
    end
    if (do_halt) begin
      tgt_nxt  = pos_r;
      mode_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pos_r       <= '0;
      tgt_r       <= '0;
      mode_r      <= 1'b0;
      dir_r       <= 1'b0;
      moving_r    <= 1'b0;
      en_n_r      <= 1'b1;
      period_r    <= '0;
      pcnt_r      <= '0;
      pulse_r     <= '0;
      step_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      tgt_r       <= tgt_nxt;
      mode_r      <= mode_nxt;
      dir_r       <= dir_nxt;
      moving_r    <= moving_nxt;
      en_n_r      <= en_n_nxt;
      period_r    <= period_nxt;
      pcnt_r      <= pcnt_nxt;
      pulse_r     <= pulse_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // status register toward the receiver
  assign out_if.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_if.step_level <= step_r;
      out_if.dir_level  <= dir_r;
      out_if.enable_n   <= en_n_r;
      out_if.position   <= pos_r;
      out_if.is_moving  <= moving_r;
      out_if.period_out <= stp_pkg::PERIOD_OUT_W'(period_r);
    end
  end

  // step output follows the pulse timer
  ap_step_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == (pulse_r != '0))
    else $error("step level out of step with pulse timer");

  // running motor has a live period and the counter below it
  ap_run_period: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (period_r != '0 && pcnt_r < period_r))
    else $error("period counter outside the period while moving");

  // stopped motor keeps period and counter cleared
  ap_stop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !moving_r |-> (period_r == '0 && pcnt_r == '0))
    else $error("period state left over while stopped");

  // finished period calculation always sets the motor running
  ap_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV && div_done) |=> moving_r)
    else $error("speed command did not start motion");

endmodule

// ===== rtl/stepper_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator: step/direction pulse generator
// Turns microsecond ticks and motion requests into step, direction and
// enable levels plus a position count for a stepper driver.
// ----------------------------------------------------------------------------
// in_if carries one request per handshake: a tick, a velocity, an absolute or
// relative move, enable or disable. out_if returns one status per request:
// step and direction levels, enable_n, position, is_moving and period, as they
// stand after that request. The APB port sets steps per revolution, minimum
// period and pulse width; write it only while no request is in flight.
// A two-entry queue sits between the decode front and the execution back.
// Tick, enable, disable and halt requests go from the back end's idle state
// straight to its status state; out_if.valid rises with the registered status.
// Velocity and move requests run the period divider: a multiply step, a setup
// step, one quotient step per period bit, a finish step and a handoff to the
// back end before the status is registered; the quotient steps are skipped
// when the period saturates.
// After reset the driver is disabled, the motor stopped, the position zero
// and the registers at 200 steps/rev, 100 us minimum period, 2 us pulse.
// When the receiver holds out_if.ready low, the status stays registered, the
// back end waits, the queue fills and in_if.ready drops.
// ----------------------------------------------------------------------------
module stepper_step_pulse_generator #(
  parameter int PERIOD_BITS = stp_pkg::PERIOD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  stp_in_if.sink                          in_if,
  stp_out_if.source                       out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [stp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [stp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [stp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [stp_pkg::SPR_W-1:0]     spr_r;
  logic [stp_pkg::MINP_W-1:0]    minp_r;
  logic [stp_pkg::PW_W-1:0]      pw_r;
  logic [stp_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;
  stp_pkg::cfg_t                 cfg;
  logic                          head_valid;
  stp_pkg::q_entry_t             head;
  logic                          pop;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[stp_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r  <= stp_pkg::SPR_RST;
      minp_r <= stp_pkg::MINP_RST;
      pw_r   <= stp_pkg::PW_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        stp_pkg::REG_SPR:  spr_r  <= pwdata[stp_pkg::SPR_W-1:0];
        stp_pkg::REG_MINP: minp_r <= pwdata[stp_pkg::MINP_W-1:0];
        stp_pkg::REG_PW:   pw_r   <= pwdata[stp_pkg::PW_W-1:0];
        default: begin
          spr_r <= spr_r;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      stp_pkg::REG_SPR:  prdata = stp_pkg::CFG_DATA_W'(spr_r);
      stp_pkg::REG_MINP: prdata = stp_pkg::CFG_DATA_W'(minp_r);
      stp_pkg::REG_PW:   prdata = stp_pkg::CFG_DATA_W'(pw_r);
      default:           prdata = '0;
    endcase
  end

  assign cfg.spr         = spr_r;
  assign cfg.min_period  = minp_r;
  assign cfg.pulse_width = pw_r;

  // decode front and command queue
  stp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // execution back end
  stp_back #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cfg        (cfg),
    .out_if     (out_if)
  );

endmodule

// ===== sim/stepper_step_pulse_generator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator_tb: self-checking bench of the step generator
// Sends ticks and motion requests over the request channel, and programs the
// three registers over APB between phases, with both ends idle. A predictor
// in the bench tracks position, direction, period and pulse state. It checks
// every returned status field by field, in order. Both channels idle and stall
// at random, except in the steady phases.
// ----------------------------------------------------------------------------
module stepper_step_pulse_generator_tb;

  localparam logic [stp_pkg::REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [stp_pkg::REQ_W-1:0] REQ_SPARE7 = 3'd7;
  localparam logic [63:0] RATE_SCALE   = 64'd65536000000;  // 1e6 ticks/s in Q16
  localparam logic [63:0] PERIOD_LIMIT = 64'h00FF_FFFF;
  localparam int DRAIN_CYCLES  = 40;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_ITEMS   = 128;

  typedef struct packed {
    logic [stp_pkg::REQ_W-1:0] kind;
    logic [stp_pkg::VEL_W-1:0] vel;
    logic [stp_pkg::VAL_W-1:0] val;
  } request_t;

  typedef struct packed {
    logic                             step;
    logic                             dir;
    logic                             en_n;
    logic [stp_pkg::POS_W-1:0]        pos;
    logic                             moving;
    logic [stp_pkg::PERIOD_OUT_W-1:0] period;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [stp_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [stp_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [stp_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  stp_in_if  req_ch ();
  stp_out_if status_ch ();

  stepper_step_pulse_generator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (req_ch),
    .out_if  (status_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted generator state and register copies
  logic [stp_pkg::SPR_W-1:0]  cfg_spr  = stp_pkg::SPR_RST;
  logic [stp_pkg::MINP_W-1:0] cfg_minp = stp_pkg::MINP_RST;
  logic [stp_pkg::PW_W-1:0]   cfg_pw   = stp_pkg::PW_RST;
  logic [31:0] pos_q = '0;
  logic [31:0] target_q = '0;
  logic        seek_mode = 1'b0;
  logic        dir_q = 1'b0;
  logic        moving_q = 1'b0;
  logic        en_n_q = 1'b1;
  logic [23:0] period_q = '0;
  logic [31:0] period_cnt = '0;
  logic [7:0]  pulse_cnt = '0;
  logic        step_q = 1'b0;

  request_t request_queue[$];
  status_t  status_expected[$];

  int errors = 0;
  int sent_count = 0;
  int done_count = 0;
  int tick_count = 0;
  int cmd_count = 0;
  int phase_items = 0;
  int steps_taken = 0;
  int settings_used = 1;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_hold = 0;
  int gap_pct = 30;
  int stall_pct = 30;
  bit req_taken = 1'b0;

  // motor halts, pulses already running finish
  function automatic void halt_stepping();
    moving_q = 1'b0;
    period_q = '0;
    period_cnt = '0;
  endfunction

  function automatic void hold_position();
    halt_stepping();
    target_q = pos_q;
    seek_mode = 1'b1;
  endfunction

  // rounded period from speed, clamped to the minimum and the counter range
  function automatic void start_run(logic [23:0] mag);
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] floor_p;
    den = 64'(cfg_spr) * 64'(mag);
    floor_p = (cfg_minp == 0) ? 64'd1 : 64'(cfg_minp);
    if (den == 0) quo = PERIOD_LIMIT;
    else quo = (2 * RATE_SCALE + den) / (2 * den);
    if (quo < floor_p) quo = floor_p;
    if (quo > PERIOD_LIMIT) quo = PERIOD_LIMIT;
    moving_q = 1'b1;
    if (quo[23:0] != period_q) begin
      period_q = quo[23:0];
      period_cnt = '0;
    end
  endfunction

  // one microsecond: pulse countdown, then period expiry and step
  function automatic void advance_tick();
    if (pulse_cnt != 0) begin
      pulse_cnt = pulse_cnt - 8'd1;
      if (pulse_cnt == 0) step_q = 1'b0;
    end
    if (!moving_q) return;
    period_cnt = period_cnt + 1;
    if (period_cnt < 32'(period_q)) return;
    period_cnt = '0;
    if (seek_mode) begin
      if (pos_q == target_q) begin
        halt_stepping();
        return;
      end
      dir_q = $signed(target_q) > $signed(pos_q);
    end
    step_q = 1'b1;
    pulse_cnt = (cfg_pw == 0) ? 8'd1 : cfg_pw;
    pos_q = dir_q ? pos_q + 32'd1 : pos_q - 32'd1;
    steps_taken++;
  endfunction

  function automatic void seek_target(logic [31:0] tgt, logic [23:0] vel);
    if (tgt == pos_q || vel[23] || vel == 0) begin
      hold_position();
    end else begin
      target_q = tgt;
      seek_mode = 1'b1;
      dir_q = $signed(tgt) > $signed(pos_q);
      start_run(vel);
    end
  endfunction

  // state after one request
  function automatic status_t apply_request(request_t r);
    status_t s;
    logic [23:0] mag;
    mag = r.vel[23] ? 24'd0 - r.vel : r.vel;
    case (r.kind)
      stp_pkg::REQ_TICK: advance_tick();
      stp_pkg::REQ_VEL: begin
        if (r.vel == 0) begin
          hold_position();
        end else begin
          dir_q = !r.vel[23];
          seek_mode = 1'b0;
          start_run(mag);
        end
      end
      stp_pkg::REQ_MOVE_AB: seek_target(r.val, r.vel);
      stp_pkg::REQ_MOVE_RL: seek_target(pos_q + r.val, r.vel);
      stp_pkg::REQ_ENABLE: en_n_q = 1'b0;
      stp_pkg::REQ_DISABLE: begin
        halt_stepping();
        en_n_q = 1'b1;
      end
      default: ;
    endcase
    s.step = step_q;
    s.dir = dir_q;
    s.en_n = en_n_q;
    s.pos = pos_q;
    s.moving = moving_q;
    s.period = period_q;
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 40)
      $display("status %0d: %s expected %0h, got %0h", done_count, what, want, got);
  endtask

  task automatic check_status(status_t want);
    if (status_ch.step_level !== want.step)
      report_mismatch("step_level", 32'(want.step), 32'(status_ch.step_level));
    if (status_ch.dir_level !== want.dir)
      report_mismatch("dir_level", 32'(want.dir), 32'(status_ch.dir_level));
    if (status_ch.enable_n !== want.en_n)
      report_mismatch("enable_n", 32'(want.en_n), 32'(status_ch.enable_n));
    if (status_ch.position !== want.pos)
      report_mismatch("position", want.pos, status_ch.position);
    if (status_ch.is_moving !== want.moving)
      report_mismatch("is_moving", 32'(want.moving), 32'(status_ch.is_moving));
    if (status_ch.period_out !== want.period)
      report_mismatch("period_out", 32'(want.period), 32'(status_ch.period_out));
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // known values from time zero
  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.velocity = '0;
    req_ch.step_value = '0;
    status_ch.ready = 1'b0;
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      req_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        req_ch.valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        request_t r;
        r = request_queue.pop_front();
        req_ch.req_type <= r.kind;
        req_ch.velocity <= r.vel;
        req_ch.step_value <= r.val;
        req_ch.valid <= 1'b1;
        in_gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // status receiver stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      status_ch.ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      status_ch.ready <= 1'b0;
    end else begin
      status_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) out_hold = pick_gap();
    end
  end

  // monitor: predict on accepted requests, check statuses, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      bit busy;
      request_t r;
      busy = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        r.kind = req_ch.req_type;
        r.vel = req_ch.velocity;
        r.val = req_ch.step_value;
        status_expected.push_back(apply_request(r));
        req_taken = 1'b1;
        busy = 1'b1;
      end
      if (status_ch.valid && status_ch.ready) begin
        if (status_expected.size() == 0) report_mismatch("status with no request", 0, 0);
        else check_status(status_expected.pop_front());
        done_count++;
        busy = 1'b1;
      end
      if (busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  task automatic cfg_write(logic [stp_pkg::REG_IDX_W-1:0] idx,
                           logic [stp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      stp_pkg::REG_SPR:  cfg_spr = data[stp_pkg::SPR_W-1:0];
      stp_pkg::REG_MINP: cfg_minp = data[stp_pkg::MINP_W-1:0];
      stp_pkg::REG_PW:   cfg_pw = data[stp_pkg::PW_W-1:0];
      default: ;
    endcase
  endtask

  // every status back, then let the back end settle
  task automatic wait_idle();
    while (done_count < sent_count) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_request(logic [stp_pkg::REQ_W-1:0] kind,
                               logic [stp_pkg::VEL_W-1:0] vel,
                               logic [stp_pkg::VAL_W-1:0] val);
    request_t r;
    while (request_queue.size() >= 2) @(negedge clk);
    r.kind = kind;
    r.vel = vel;
    r.val = val;
    request_queue.push_back(r);
    sent_count++;
    if (kind == stp_pkg::REQ_TICK) tick_count++;
    else if (kind <= stp_pkg::REQ_DISABLE) cmd_count++;
    if (kind <= stp_pkg::REQ_DISABLE) phase_items++;
  endtask

  // request with random don't-care fields
  task automatic queue_noisy(logic [stp_pkg::REQ_W-1:0] kind);
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    queue_request(kind, a[stp_pkg::VEL_W-1:0], b);
  endtask

  // speed giving a short period under the current setting, sometimes any speed
  function automatic logic [23:0] pick_speed();
    logic [63:0] m;
    if (cfg_spr == 0 || $urandom_range(0, 9) < 3) return 24'($urandom_range(1, 24'h7FFFFF));
    m = RATE_SCALE / (64'(cfg_spr) * 64'($urandom_range(1, 24)));
    if (m == 0) m = 64'd1;
    if (m > 64'h7FFFFF) m = 64'h7FFFFF;
    return m[23:0];
  endfunction

  function automatic logic [23:0] move_speed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return pick_speed();
    if (r < 93) return 24'd0 - pick_speed();
    return 24'd0;
  endfunction

  // one register setting, then command/tick-burst sequences
  task automatic run_phase(logic [15:0] spr, logic [15:0] minp, logic [7:0] pw, bit steady);
    int r;
    logic [23:0] vel;
    logic [31:0] tgt;
    logic [31:0] noise;
    wait_idle();
    cfg_write(stp_pkg::REG_SPR, 32'(spr));
    cfg_write(stp_pkg::REG_MINP, 32'(minp));
    cfg_write(stp_pkg::REG_PW, 32'(pw));
    settings_used++;
    gap_pct = steady ? 0 : 30;
    stall_pct = steady ? 0 : 30;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      noise = $urandom;
      if (r < 4) begin
        queue_noisy(stp_pkg::REQ_ENABLE);
      end else if (r < 7) begin
        queue_noisy(stp_pkg::REQ_DISABLE);
      end else if (r < 9) begin
        queue_noisy($urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7);
      end else if (r < 40) begin
        vel = pick_speed();
        if ($urandom_range(0, 3) == 0) vel = 24'd0 - vel;
        if ($urandom_range(0, 19) == 0) vel = 24'd0;
        queue_request(stp_pkg::REQ_VEL, vel, noise);
      end else if (r < 70) begin
        tgt = ($urandom_range(0, 9) < 8) ? pos_q + 32'($urandom_range(0, 50)) - 32'd25
                                         : noise;
        queue_request(stp_pkg::REQ_MOVE_AB, move_speed(), tgt);
      end else begin
        tgt = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 50)) - 32'd25 : noise;
        queue_request(stp_pkg::REQ_MOVE_RL, move_speed(), tgt);
      end
      repeat ($urandom_range(2, 40)) queue_noisy(stp_pkg::REQ_TICK);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: register reset values, speed and target extremes, stop cases
    queue_request(stp_pkg::REQ_TICK, 24'h000000, 32'h00000000);
    queue_request(stp_pkg::REQ_ENABLE, 24'h000000, 32'h00000000);
    queue_request(stp_pkg::REQ_VEL, 24'h7FFFFF, 32'h00000000);
    queue_request(stp_pkg::REQ_TICK, 24'h000000, 32'h00000000);
    queue_request(stp_pkg::REQ_VEL, 24'h800000, 32'h00000000);
    queue_request(stp_pkg::REQ_TICK, 24'h000000, 32'h00000000);
    queue_request(stp_pkg::REQ_VEL, 24'hFFFFFF, 32'h00000000);
    queue_request(stp_pkg::REQ_VEL, 24'h000001, 32'h00000000);
    queue_request(stp_pkg::REQ_VEL, 24'h000000, 32'h00000000);
    // moves that only stop: to the current position, reverse or zero speed
    queue_request(stp_pkg::REQ_MOVE_AB, 24'h010000, pos_q);
    queue_request(stp_pkg::REQ_MOVE_AB, 24'hFF0000, 32'd5);
    queue_request(stp_pkg::REQ_MOVE_AB, 24'h000000, 32'd5);
    queue_request(stp_pkg::REQ_MOVE_RL, 24'h010000, 32'd0);
    queue_request(stp_pkg::REQ_MOVE_AB, 24'h7FFFFF, 32'h7FFFFFFF);
    queue_request(stp_pkg::REQ_TICK, 24'h000000, 32'h00000000);
    queue_request(stp_pkg::REQ_MOVE_RL, 24'h010000, 32'h80000000);
    queue_request(stp_pkg::REQ_MOVE_AB, 24'h000100, 32'hFFFFFFFF);
    queue_request(REQ_SPARE6, 24'hFFFFFF, 32'hFFFFFFFF);
    queue_request(REQ_SPARE7, 24'h800000, 32'h80000000);
    queue_request(stp_pkg::REQ_DISABLE, 24'h000000, 32'h00000000);
    queue_request(stp_pkg::REQ_TICK, 24'hFFFFFF, 32'hFFFFFFFF);

    // random phases, register extremes first
    run_phase(16'd65535, 16'd1, 8'd1, 1'b1);
    run_phase(16'd0, 16'd0, 8'd0, 1'b0);
    run_phase(16'd1, 16'd65535, 8'd255, 1'b0);
    run_phase(16'd40000, 16'd2, 8'd3, 1'b0);
    run_phase(16'd50000, 16'd0, 8'd200, 1'b0);
    run_phase(16'($urandom_range(1000, 65535)), 16'($urandom_range(0, 8)),
              8'($urandom_range(0, 12)), 1'b1);
    run_phase(16'($urandom_range(1000, 65535)), 16'($urandom_range(0, 8)),
              8'($urandom_range(0, 12)), 1'b0);
    run_phase(16'($urandom_range(1000, 65535)), 16'($urandom_range(0, 8)),
              8'($urandom_range(0, 12)), 1'b0);
    wait_idle();

    if (status_expected.size() != 0)
      report_mismatch("statuses never returned", status_expected.size(), 0);
    $display("run covered %0d ticks and %0d motion requests under %0d register settings",
             tick_count, cmd_count, settings_used);
    $display("%0d statuses checked, %0d steps generated", done_count, steps_taken);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
